/* rtl/svpwm_mmd_pkg.sv */
package svpwm_mmd_pkg;

    // Field widths of the two channels.
    localparam int VOLT_WIDTH     = 16;
    localparam int DUTY_FRAC_BITS = 15;
    localparam int DUTY_W         = DUTY_FRAC_BITS + 1;

    // sqrt(3)/2 as unsigned Q0.16, held with a leading zero so that it multiplies as signed.
    localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;
    localparam logic [VOLT_WIDTH-1:0] BUS_MIN_CODES = VOLT_WIDTH'(64);

    // Internal widths.
    localparam int PH_W   = VOLT_WIDTH + 17;  // phase voltage, Q16, signed
    localparam int DIFF_W = VOLT_WIDTH + 19;  // doubled offset phase voltage, signed
    localparam int MAG_W  = DIFF_W - 1;       // its magnitude
    localparam int REM_W  = VOLT_WIDTH + 16;  // divisor (bus << 16) and partial remainder

    // Front stages, one stage per quotient bit, one output stage.
    localparam int NUM_STAGES = DUTY_FRAC_BITS + 4;

    localparam logic [DUTY_W-1:0] DUTY_ZERO = '0;
    localparam logic [DUTY_W-1:0] DUTY_HALF = DUTY_W'(1) << (DUTY_FRAC_BITS - 1);
    localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1) << DUTY_FRAC_BITS;

    typedef struct packed {
        logic signed [VOLT_WIDTH-1:0] v_alpha;
        logic signed [VOLT_WIDTH-1:0] v_beta;
        logic        [VOLT_WIDTH-1:0] bus_voltage;
    } t_svpwm_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_u;
        logic [DUTY_W-1:0] duty_v;
        logic [DUTY_W-1:0] duty_w;
        logic              bus_low;
    } t_svpwm_out;

    // One phase on its way through the divider.
    typedef struct packed {
        logic [REM_W-1:0]          rem;
        logic [DUTY_FRAC_BITS-1:0] q;
        logic                      neg;
        logic                      sat;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [2:0]  lane;
        logic [REM_W-1:0] den;
        logic             low;
    } t_div_beat;

endpackage

/* rtl/svpwm_min_max_duty.sv */
// Space-vector PWM duty generator with min-max common-mode injection. Each input beat carries
// an alpha/beta voltage command and the DC bus voltage, all in units of 1/64 V; each output beat
// carries the three phase duties in Q1.15 (32768 is 100 percent, clamped to 0..32768) and a
// bus_low flag. When the bus is below 1 V (64 codes) every duty is one half and bus_low is set.
// Otherwise the phases come from an inverse Clarke transform with sqrt(3)/2 held as 56756/65536,
// the offset -(max+min)/2 is added, and each duty is 0.5 + phase/bus, rounded to nearest with
// ties away from zero. The block takes one beat per clock cycle while its input is not stalled
// and gives exactly one result per beat, in order. The pipeline holds three front stages
// (beta multiply, inverse Clarke with max/min search, offset and magnitude), one restoring
// divider stage per quotient bit for all three phases side by side, and the rounding and clamp
// stage that drives the output register. Each stage moves on as soon as the stage after it is
// free, so bubbles close up and new beats keep entering while a finished result waits on a
// stalled output. The block holds no state between beats.
module svpwm_min_max_duty (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  svpwm_mmd_pkg::t_svpwm_in  i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output svpwm_mmd_pkg::t_svpwm_out o_data
);

    localparam int F    = svpwm_mmd_pkg::DUTY_FRAC_BITS;
    localparam int NST  = svpwm_mmd_pkg::NUM_STAGES;
    localparam int LAST = NST - 1;

    // Valid bit of every pipeline stage, and whether that stage loads on this edge.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_adv;

    // A stage may load when it is empty or when its contents move on to the next stage.
    assign w_adv[LAST] = !r_vld[LAST] || !i_stall;
    for (genvar k = 0; k < LAST; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[LAST];

    // Front end: multiply, inverse Clarke, min-max offset.
    svpwm_mmd_pkg::t_div_beat w_beat [F+1];

    svpwm_mmd_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_adv[2:0]),
        .i_data (i_data),
        .o_beat (w_beat[0])
    );

    // Divider: one quotient bit per stage.
    for (genvar k = 0; k < F; k++) begin : g_div
        svpwm_mmd_div_step u_step (
            .i_clk  (i_clk),
            .i_en   (w_adv[3+k]),
            .i_beat (w_beat[k]),
            .o_beat (w_beat[k+1])
        );
    end

    // Rounding, clamp and the output register.
    svpwm_mmd_out u_out (
        .i_clk  (i_clk),
        .i_en   (w_adv[LAST]),
        .i_beat (w_beat[F]),
        .o_data (o_data)
    );

    // A low-bus result always carries one half on every phase.
    a_low_bus_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.bus_low) |->
            (o_data.duty_u == svpwm_mmd_pkg::DUTY_HALF) &&
            (o_data.duty_v == svpwm_mmd_pkg::DUTY_HALF) &&
            (o_data.duty_w == svpwm_mmd_pkg::DUTY_HALF))
        else $error("low bus result without half duties");

    // No duty ever goes beyond 100 percent.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_data.duty_u <= svpwm_mmd_pkg::DUTY_FULL) &&
            (o_data.duty_v <= svpwm_mmd_pkg::DUTY_FULL) &&
            (o_data.duty_w <= svpwm_mmd_pkg::DUTY_FULL))
        else $error("duty above full scale");

    // With the output stage empty the whole pipeline must be free to move.
    a_empty_out_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[LAST] |-> !o_stall)
        else $error("input stalled while the output stage is empty");

endmodule

/* rtl/svpwm_mmd_front.sv */
module svpwm_mmd_front (
    input  logic                     i_clk,
    input  logic [2:0]               i_en,
    input  svpwm_mmd_pkg::t_svpwm_in i_data,
    output svpwm_mmd_pkg::t_div_beat o_beat
);

    localparam int VW     = svpwm_mmd_pkg::VOLT_WIDTH;
    localparam int PH_W   = svpwm_mmd_pkg::PH_W;
    localparam int DIFF_W = svpwm_mmd_pkg::DIFF_W;
    localparam int MAG_W  = svpwm_mmd_pkg::MAG_W;
    localparam int REM_W  = svpwm_mmd_pkg::REM_W;

    // Stage one: the beta product.
    logic signed [VW-1:0]   r_a;
    logic signed [PH_W-1:0] r_kb;
    logic [VW-1:0]          r_bus1;
    logic                   r_low1;
    logic signed [PH_W-1:0] n_kb;

    assign n_kb = PH_W'(i_data.v_beta) * PH_W'($signed(svpwm_mmd_pkg::SQRT3_HALF_Q16));

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a    <= i_data.v_alpha;
            r_kb   <= n_kb;
            r_bus1 <= i_data.bus_voltage;
            r_low1 <= (i_data.bus_voltage < svpwm_mmd_pkg::BUS_MIN_CODES);
        end
    end

    // Stage two: inverse Clarke, then the largest and smallest phase.
    logic signed [PH_W-1:0] w_ah;
    logic signed [PH_W-1:0] w_v [3];
    logic signed [PH_W-1:0] w_hi1, w_lo1, w_mx, w_mn;

    assign w_ah   = PH_W'($signed({r_a, 15'h0}));
    assign w_v[0] = PH_W'($signed({r_a, 16'h0}));
    assign w_v[1] = r_kb - w_ah;
    assign w_v[2] = -r_kb - w_ah;
    assign w_hi1  = (w_v[0] > w_v[1]) ? w_v[0] : w_v[1];
    assign w_lo1  = (w_v[0] < w_v[1]) ? w_v[0] : w_v[1];
    assign w_mx   = (w_v[2] > w_hi1) ? w_v[2] : w_hi1;
    assign w_mn   = (w_v[2] < w_lo1) ? w_v[2] : w_lo1;

    logic signed [PH_W-1:0] r_v [3];
    logic signed [PH_W-1:0] r_mx, r_mn;
    logic [VW-1:0]          r_bus2;
    logic                   r_low2;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_v[0] <= w_v[0];
            r_v[1] <= w_v[1];
            r_v[2] <= w_v[2];
            r_mx   <= w_mx;
            r_mn   <= w_mn;
            r_bus2 <= r_bus1;
            r_low2 <= r_low1;
        end
    end

    // Stage three: doubled offset voltage, its sign and magnitude, and the saturation test.
    logic signed [DIFF_W-1:0] w_sum;
    logic [REM_W-1:0]         w_den;
    svpwm_mmd_pkg::t_div_beat n_beat;
    svpwm_mmd_pkg::t_div_beat r_beat;

    assign w_sum = DIFF_W'(r_mx) + DIFF_W'(r_mn);
    assign w_den = {r_bus2, 16'h0};

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic signed [DIFF_W-1:0] w_d;
        logic signed [DIFF_W-1:0] w_abs;
        logic [MAG_W-1:0]         w_n;

        assign w_d   = (DIFF_W'(r_v[g]) <<< 1) - w_sum;
        assign w_abs = w_d[DIFF_W-1] ? -w_d : w_d;
        assign w_n   = w_abs[MAG_W-1:0];

        assign n_beat.lane[g].rem = w_n[REM_W-1:0];
        assign n_beat.lane[g].q   = '0;
        assign n_beat.lane[g].neg = w_d[DIFF_W-1];
        assign n_beat.lane[g].sat = (w_n >= MAG_W'(w_den));
    end

    assign n_beat.den = w_den;
    assign n_beat.low = r_low2;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

/* rtl/svpwm_mmd_div_step.sv */
module svpwm_mmd_div_step (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  svpwm_mmd_pkg::t_div_beat i_beat,
    output svpwm_mmd_pkg::t_div_beat o_beat
);

    localparam int REM_W = svpwm_mmd_pkg::REM_W;
    localparam int F     = svpwm_mmd_pkg::DUTY_FRAC_BITS;

    svpwm_mmd_pkg::t_div_beat n_beat;
    svpwm_mmd_pkg::t_div_beat r_beat;

    // One restoring step: shift the remainder, subtract the divisor where it fits.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic [REM_W:0] w_t;
        logic [REM_W:0] w_diff;
        logic           w_ge;

        assign w_t    = {i_beat.lane[g].rem, 1'b0};
        assign w_diff = w_t - {1'b0, i_beat.den};
        assign w_ge   = (w_t >= {1'b0, i_beat.den});

        assign n_beat.lane[g].rem = w_ge ? w_diff[REM_W-1:0] : w_t[REM_W-1:0];
        assign n_beat.lane[g].q   = {i_beat.lane[g].q[F-2:0], w_ge};
        assign n_beat.lane[g].neg = i_beat.lane[g].neg;
        assign n_beat.lane[g].sat = i_beat.lane[g].sat;
    end

    assign n_beat.den = i_beat.den;
    assign n_beat.low = i_beat.low;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

/* rtl/svpwm_mmd_out.sv */
module svpwm_mmd_out (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  svpwm_mmd_pkg::t_div_beat  i_beat,
    output svpwm_mmd_pkg::t_svpwm_out o_data
);

    localparam int F      = svpwm_mmd_pkg::DUTY_FRAC_BITS;
    localparam int DUTY_W = svpwm_mmd_pkg::DUTY_W;

    logic [DUTY_W-1:0] w_duty [3];

    // Round the quotient to nearest, then fold it around one half and clamp.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic [F:0]        w_qp1;
        logic [DUTY_W-1:0] w_mag;

        assign w_qp1 = {1'b0, i_beat.lane[g].q} + (F+1)'(1);
        assign w_mag = DUTY_W'(w_qp1[F:1]);

        always_comb begin
            priority if (i_beat.low) begin
                w_duty[g] = svpwm_mmd_pkg::DUTY_HALF;
            end else if (i_beat.lane[g].sat) begin
                w_duty[g] = i_beat.lane[g].neg ? svpwm_mmd_pkg::DUTY_ZERO
                                               : svpwm_mmd_pkg::DUTY_FULL;
            end else if (i_beat.lane[g].neg) begin
                w_duty[g] = (w_mag >= svpwm_mmd_pkg::DUTY_HALF) ? svpwm_mmd_pkg::DUTY_ZERO
                                                                : svpwm_mmd_pkg::DUTY_HALF - w_mag;
            end else begin
                w_duty[g] = svpwm_mmd_pkg::DUTY_HALF + w_mag;
            end
        end
    end

    svpwm_mmd_pkg::t_svpwm_out r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data.duty_u  <= w_duty[0];
            r_data.duty_v  <= w_duty[1];
            r_data.duty_w  <= w_duty[2];
            r_data.bus_low <= i_beat.low;
        end
    end

    assign o_data = r_data;

endmodule

/* verif/svpwm_min_max_duty_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the min-max injection SVPWM duty block. Every input beat that
// the block accepts is run through a behavioural duty predictor here, and its result is
// queued. Each output beat is then checked field by field against the oldest queued result.
// The stimulus is a short directed set first: the bus-low threshold, the field extremes and
// the exact clamp boundary. Randomised traffic follows under several idling mixes, with one
// long receiver hold-off that fills the pipeline and forces the input stall.
module svpwm_min_max_duty_tb;

    localparam int VW     = svpwm_mmd_pkg::VOLT_WIDTH;
    localparam int FRAC   = svpwm_mmd_pkg::DUTY_FRAC_BITS;
    localparam int DUTY_W = svpwm_mmd_pkg::DUTY_W;

    // A long hold-off must outlast the pipeline by a wide margin, so that the input stalls.
    localparam int HOLD_OFF_CYCLES = 300;
    // The longest quiet stretch in a correct run is the hold-off above. The limit is several times that.
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    svpwm_mmd_pkg::t_svpwm_in  i_data;
    logic                      o_valid;
    logic                      i_stall;
    svpwm_mmd_pkg::t_svpwm_out o_data;

    // Results that are still owed by the block, oldest first.
    svpwm_mmd_pkg::t_svpwm_out duty_queue[$];
    svpwm_mmd_pkg::t_svpwm_out want;

    // Idling switches for each side, and a hold-off request for the receiver.
    bit tx_idle_on;
    bit rx_idle_on;
    int hold_req;

    int fail_count;
    int quiet_cycles;
    int beats_sent;
    int low_bus_beats;
    int clamped_duties;
    int in_stall_cycles;

    svpwm_min_max_duty dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    // The duty of one phase, given its doubled and offset voltage d and the divisor bus << 16.
    // Once the magnitude reaches the divisor, the offset alone is at least one half, so the
    // duty goes straight to its rail. Otherwise the quotient is taken to F fractional bits
    // and then halved, rounding to nearest with ties away from zero.
    function automatic logic [DUTY_W-1:0] phase_duty(input longint d, input longint den);
        longint n;
        longint q;
        longint mag;
        longint half;
        longint full;
        half = longint'(1) << (FRAC - 1);
        full = longint'(1) << FRAC;
        n = (d < 0) ? -d : d;
        if (n >= den) begin
            return (d < 0) ? svpwm_mmd_pkg::DUTY_ZERO : svpwm_mmd_pkg::DUTY_FULL;
        end
        q = (n << FRAC) / den;
        mag = (q + 1) >> 1;
        if (d < 0) begin
            return (mag >= half) ? svpwm_mmd_pkg::DUTY_ZERO : DUTY_W'(half - mag);
        end
        return (half + mag > full) ? svpwm_mmd_pkg::DUTY_FULL : DUTY_W'(half + mag);
    endfunction

    // The whole result for one vector: an inverse Clarke transform in Q16, then min-max
    // injection. The injection is kept doubled, so no bit is lost in the halving.
    function automatic svpwm_mmd_pkg::t_svpwm_out predict_duties(
        input svpwm_mmd_pkg::t_svpwm_in x);
        svpwm_mmd_pkg::t_svpwm_out r;
        longint a;
        longint b;
        longint bus;
        longint kb;
        longint ph_u;
        longint ph_v;
        longint ph_w;
        longint top;
        longint bot;
        longint den;
        a   = longint'(x.v_alpha);
        b   = longint'(x.v_beta);
        bus = longint'(x.bus_voltage);
        if (bus < longint'(svpwm_mmd_pkg::BUS_MIN_CODES)) begin
            r.duty_u  = svpwm_mmd_pkg::DUTY_HALF;
            r.duty_v  = svpwm_mmd_pkg::DUTY_HALF;
            r.duty_w  = svpwm_mmd_pkg::DUTY_HALF;
            r.bus_low = 1'b1;
            return r;
        end
        kb   = b * longint'(svpwm_mmd_pkg::SQRT3_HALF_Q16);
        ph_u = a * 65536;
        ph_v = -(a * 32768) + kb;
        ph_w = -(a * 32768) - kb;
        top  = ph_u;
        bot  = ph_u;
        if (ph_v > top) top = ph_v;
        if (ph_w > top) top = ph_w;
        if (ph_v < bot) bot = ph_v;
        if (ph_w < bot) bot = ph_w;
        den = bus << 16;
        r.duty_u  = phase_duty(2 * ph_u - top - bot, den);
        r.duty_v  = phase_duty(2 * ph_v - top - bot, den);
        r.duty_w  = phase_duty(2 * ph_w - top - bot, den);
        r.bus_low = 1'b0;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // Offers one beat after a random gap and holds it until the block takes it. Valid is
    // lowered only when there is a gap, so that back-to-back beats keep it high throughout.
    task automatic send_beat(input logic signed [VW-1:0] alpha,
                             input logic signed [VW-1:0] beta,
                             input logic [VW-1:0] bus);
        svpwm_mmd_pkg::t_svpwm_in beat;
        int gap;
        beat.v_alpha     = alpha;
        beat.v_beta      = beta;
        beat.bus_voltage = bus;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (o_stall);
        duty_queue.push_back(predict_duties(beat));
        beats_sent++;
    endtask

    // A random vector. Most of them are scaled to the bus, so that the duties mostly stay off the
    // rails and the rounding is exercised. The remainder are raw random words, bus-low beats
    // or beats that sit right at the 1 V threshold.
    task automatic send_random_beat();
        int kind;
        int bus;
        int span;
        int alpha;
        int beta;
        kind = $urandom_range(0, 9);
        if (kind <= 1) begin
            alpha = $urandom;
            beta  = $urandom;
            bus   = $urandom;
        end else if (kind == 2) begin
            alpha = $urandom;
            beta  = $urandom;
            bus   = $urandom_range(0, 63);
        end else if (kind == 3) begin
            bus   = $urandom_range(60, 70);
            alpha = $urandom_range(0, 160) - 80;
            beta  = $urandom_range(0, 160) - 80;
        end else begin
            bus = $urandom & ((1 << $urandom_range(7, 16)) - 1);
            if (bus < 64) bus = 64 + bus;
            span = (bus * 3) / 4;
            if (span > 32767) span = 32767;
            alpha = $urandom_range(0, 2 * span) - span;
            beta  = $urandom_range(0, 2 * span) - span;
        end
        send_beat(VW'(alpha), VW'(beta), VW'(bus));
    endtask

    // The 1 V threshold from both sides. Below it the vector must not matter at all.
    task automatic test_bus_threshold();
        send_beat(16'sd0, 16'sd0, 16'd63);
        send_beat(16'sd32767, -16'sd32768, 16'd0);
        send_beat(-16'sd32768, 16'sd32767, 16'd63);
        send_beat(16'sd0, 16'sd0, 16'd64);
        send_beat(16'sd123, -16'sd456, 16'd64);
        send_beat(16'sd0, 16'sd0, 16'd65535);
    endtask

    // The extremes of every field, including full-scale vectors on the smallest valid bus.
    task automatic test_field_extremes();
        send_beat(16'sd32767, 16'sd0, 16'd65535);
        send_beat(-16'sd32768, 16'sd0, 16'd65535);
        send_beat(16'sd0, 16'sd32767, 16'd65535);
        send_beat(16'sd0, -16'sd32768, 16'd65535);
        send_beat(16'sd32767, 16'sd32767, 16'd64);
        send_beat(-16'sd32768, -16'sd32768, 16'd64);
        send_beat(16'sd32767, -16'sd32768, 16'd1000);
        send_beat(-16'sd1, -16'sd1, 16'd65535);
        send_beat(16'sd1, 16'sd1, 16'd64);
    endtask

    // With beta at zero, the doubled U phase offset is 1.5 alpha. A bus of 1.5 alpha puts it exactly
    // on the clamp threshold, and one code more leaves it just inside the range.
    task automatic test_clamp_boundary();
        send_beat(16'sd64, 16'sd0, 16'd96);
        send_beat(16'sd64, 16'sd0, 16'd97);
        send_beat(-16'sd64, 16'sd0, 16'd96);
        send_beat(-16'sd64, 16'sd0, 16'd95);
        send_beat(16'sd20000, 16'sd0, 16'd30000);
    endtask

    task automatic test_random_traffic(input bit tx_idle, input bit rx_idle, input int count);
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        repeat (count) send_random_beat();
    endtask

    // The receiver holds off for a long stretch while beats keep arriving back to back. The
    // pipeline fills up, and the block has to stall its input without losing a beat.
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = HOLD_OFF_CYCLES;
        repeat (80) send_random_beat();
    endtask

    // Receiver side. It waits a drawn number of cycles before each beat, or a long hold-off
    // when one has been requested. The count is kept here, so that the sender is not blocked.
    initial begin
        int wait_cycles;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (hold_req > 0) begin
                wait_cycles = hold_req;
                hold_req = 0;
            end else begin
                wait_cycles = rx_idle_on ? $urandom_range(0, 11) : 0;
            end
            if (wait_cycles > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (wait_cycles - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Result check and watchdog. Both are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall) in_stall_cycles++;
            if (o_valid && !i_stall) begin
                if (duty_queue.size() == 0) begin
                    $error("result beat arrived with nothing outstanding");
                    fail_count++;
                end else begin
                    want = duty_queue.pop_front();
                    check_field("duty_u", want.duty_u, o_data.duty_u);
                    check_field("duty_v", want.duty_v, o_data.duty_v);
                    check_field("duty_w", want.duty_w, o_data.duty_w);
                    check_field("bus_low", want.bus_low, o_data.bus_low);
                    if (want.bus_low) low_bus_beats++;
                    clamped_duties += (want.duty_u == svpwm_mmd_pkg::DUTY_ZERO ||
                                       want.duty_u == svpwm_mmd_pkg::DUTY_FULL);
                    clamped_duties += (want.duty_v == svpwm_mmd_pkg::DUTY_ZERO ||
                                       want.duty_v == svpwm_mmd_pkg::DUTY_FULL);
                    clamped_duties += (want.duty_w == svpwm_mmd_pkg::DUTY_ZERO ||
                                       want.duty_w == svpwm_mmd_pkg::DUTY_FULL);
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("no beat has moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        i_data     = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req   = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_bus_threshold();
        test_field_extremes();
        test_clamp_boundary();
        test_random_traffic(1'b1, 1'b1, 600);
        test_output_backpressure();
        test_random_traffic(1'b0, 1'b0, 300);
        test_random_traffic(1'b1, 1'b0, 270);
        test_random_traffic(1'b0, 1'b1, 270);

        @(negedge i_clk);
        i_valid <= 1'b0;
        // The watchdog still guards this wait. Afterwards, a stray late beat is given time to show.
        while (duty_queue.size() != 0) @(posedge i_clk);
        repeat (svpwm_mmd_pkg::NUM_STAGES + 8) @(posedge i_clk);

        $display("Sent %0d vector beats: %0d with the bus below 1 V, %0d duties on a rail.",
                 beats_sent, low_bus_beats, clamped_duties);
        $display("The input was held off for %0d cycles by output back-pressure.",
                 in_stall_cycles);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
